/* design/four_channel_fading_pwm_macros.svh */
// Assertion macros for the fading PWM top-level design file.
`ifndef FOUR_CHANNEL_FADING_PWM_MACROS_SVH
`define FOUR_CHANNEL_FADING_PWM_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset.
`define FCPWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcpwm assertion failed");

// Next-cycle implication, disabled while in reset.
`define FCPWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcpwm assertion failed");

`else

`define FCPWM_ASSERT_IMP(lbl, ante, cons)
`define FCPWM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* design/fcpwm_pkg.sv */
// Package: constants, opcodes and control struct for the fading PWM driver.
`default_nettype none

package fcpwm_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int DUTY_W    = 16;
  localparam int OPCODE_W  = 2;
  localparam int CHANNEL_W = 8;
  localparam int LEVELS_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PWM_TICK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RAMP_TICK = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_DUTY  = 2'd2;

  localparam logic [CHANNEL_W-1:0] CH_ALL = 8'hff;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN   = 2'd1;

  localparam logic [DUTY_W-1:0] PERIOD_MAX_RST = 16'd100;
  localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = 16'd0;

  // Per-word strobes from the top level to each channel.
  typedef struct packed {
    logic pwm;   // pwm tick applied this cycle
    logic ramp;  // ramp tick applied this cycle
    logic wrap;  // counter at or past period_max, wraps on a pwm tick
    logic set;   // load clamped width as target
  } fcpwm_ctl_t;

endpackage

`default_nettype wire

/* design/fcpwm_chan.sv */
// One PWM channel: current and target duty, ramping, and output level.
`default_nettype none

module fcpwm_chan #(
  parameter int COUNT_BITS = fcpwm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fcpwm_pkg::fcpwm_ctl_t         ctl,
  input  wire logic [COUNT_BITS-1:0]         cnt_eff,
  input  wire logic [fcpwm_pkg::DUTY_W-1:0]  period_max,
  input  wire logic [fcpwm_pkg::DUTY_W-1:0]  duty_min,
  input  wire logic [fcpwm_pkg::DUTY_W-1:0]  set_width,
  output logic                               led
);
  import fcpwm_pkg::*;

  localparam int CMP_W = (COUNT_BITS > DUTY_W) ? COUNT_BITS : DUTY_W;

  logic [DUTY_W-1:0] cur_r, cur_nxt;
  logic [DUTY_W-1:0] tgt_r, tgt_nxt;
  logic              led_r, led_nxt;

  always_comb begin
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    led_nxt = led_r;
    if (ctl.pwm) begin
      if (ctl.wrap && (cur_r != duty_min)) begin
        led_nxt = 1'b1;
      end
      if ((CMP_W'(cnt_eff) >= CMP_W'(cur_r)) && (cur_r != period_max)) begin
        led_nxt = 1'b0;
      end
    end
    if (ctl.ramp) begin
      if (cur_r < tgt_r) begin
        cur_nxt = cur_r + 1'b1;
      end else if (cur_r > tgt_r) begin
        cur_nxt = cur_r - 1'b1;
      end
    end
    if (ctl.set) begin
      tgt_nxt = set_width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= DUTY_MIN_RST;
      tgt_r <= DUTY_MIN_RST;
      led_r <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      tgt_r <= tgt_nxt;
      led_r <= led_nxt;
    end
  end

  // level as it stands once the current word is applied
  assign led = led_nxt;

endmodule

`default_nettype wire

/* design/four_channel_fading_pwm.sv */
// Top level of the multi-channel LED PWM driver with duty fading.
`default_nettype none

// Multi-channel LED PWM driver with soft fading. Each input word carries an
// opcode: a PWM tick advances the shared period counter (wrapping once it
// reaches period_max) and updates every LED level; a ramp tick moves each
// channel's current duty one count toward its target; a set-duty word clamps
// width into [duty_min, period_max] (duty_min wins if they cross) and stores
// it as target of channel 1..NUM_CHANNELS, or of all channels for 255.
// Every word returns one result word with the LED levels after it applied.
// Throughput is one word per clock while out_ready is high; each word passes
// the input register and then the result register, with all per-word work
// between them. A word is taken while a finished result still waits on
// out_ready; the input stalls only when both registers are full.
// Configuration writes (index 0 period_max, index 1 duty_min) take effect
// from the next word on and should be issued only while the block is idle.

module four_channel_fading_pwm #(
  parameter int NUM_CHANNELS = fcpwm_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = fcpwm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [fcpwm_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [fcpwm_pkg::CHANNEL_W-1:0]  in_channel,
  input  wire logic [fcpwm_pkg::DUTY_W-1:0]     in_width,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [fcpwm_pkg::LEVELS_W-1:0]        out_led_levels,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [fcpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcpwm_pkg::DUTY_W-1:0]     cfg_wdata
);
  import fcpwm_pkg::*;

`include "four_channel_fading_pwm_macros.svh"

  localparam int CMP_W   = (COUNT_BITS > DUTY_W) ? COUNT_BITS : DUTY_W;
  localparam int VIS_CHS = (NUM_CHANNELS < LEVELS_W) ? NUM_CHANNELS : LEVELS_W;

  // config registers
  logic [DUTY_W-1:0] period_max_r;
  logic [DUTY_W-1:0] duty_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_max_r <= PERIOD_MAX_RST;
      duty_min_r   <= DUTY_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD_MAX: period_max_r <= cfg_wdata;
        REG_DUTY_MIN:   duty_min_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // input register
  logic                 s_valid_r;
  logic [OPCODE_W-1:0]  s_opcode_r;
  logic [CHANNEL_W-1:0] s_channel_r;
  logic [DUTY_W-1:0]    s_width_r;

  // result register
  logic                 out_valid_r;
  logic [LEVELS_W-1:0]  out_led_levels_r, out_led_levels_nxt;

  // stage word moves into the result register
  logic adv;
  assign adv      = s_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_opcode_r  <= in_opcode;
      s_channel_r <= in_channel;
      s_width_r   <= in_width;
    end
  end

  // shared period counter
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic                  wrap;
  logic                  do_pwm, do_ramp, do_set;

  assign do_pwm  = adv && (s_opcode_r == OP_PWM_TICK);
  assign do_ramp = adv && (s_opcode_r == OP_RAMP_TICK);
  assign do_set  = adv && (s_opcode_r == OP_SET_DUTY);

  assign wrap    = CMP_W'(cnt_r) >= CMP_W'(period_max_r);
  assign cnt_eff = wrap ? '0 : cnt_r;
  assign cnt_nxt = do_pwm ? (cnt_eff + 1'b1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // clamp: limit to max first, then raise to min
  logic [DUTY_W-1:0] w_hi, set_width;
  assign w_hi      = (s_width_r > period_max_r) ? period_max_r : s_width_r;
  assign set_width = (w_hi < duty_min_r) ? duty_min_r : w_hi;

  // per-channel level after the word in the stage
  logic [NUM_CHANNELS-1:0] led;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_ch
    fcpwm_ctl_t ctl;
    logic       sel;
    assign sel      = (s_channel_r == CH_ALL) ||
                      (s_channel_r == CHANNEL_W'(g + 1));
    assign ctl.pwm  = do_pwm;
    assign ctl.ramp = do_ramp;
    assign ctl.wrap = wrap;
    assign ctl.set  = do_set && sel;

    fcpwm_chan #(
      .COUNT_BITS (COUNT_BITS)
    ) u_chan (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cnt_eff    (cnt_eff),
      .period_max (period_max_r),
      .duty_min   (duty_min_r),
      .set_width  (set_width),
      .led        (led[g])
    );
  end

  // only the low channels are visible in the result word
  always_comb begin
    out_led_levels_nxt = '0;
    for (int i = 0; i < VIS_CHS; i++) begin
      out_led_levels_nxt[i] = led[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_led_levels_r <= out_led_levels_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_levels = out_led_levels_r;

  `FCPWM_ASSERT_NXT(a_stage_hold, s_valid_r && !adv, s_valid_r && $stable(s_opcode_r))
  `FCPWM_ASSERT_NXT(a_cnt_only_pwm, rst_n && !do_pwm, $stable(cnt_r))
  `FCPWM_ASSERT_NXT(a_wrap_restart, do_pwm && wrap, cnt_r == COUNT_BITS'(1))

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for the four-channel fading LED PWM driver: stimulus, prediction and result check.
`timescale 1ns / 100ps

module tb_top;
  import fcpwm_pkg::*;

  // Opcode 3 has no name in the package; it must leave all state alone.
  localparam logic [OPCODE_W-1:0]  OP_UNUSED   = 2'd3;
  // Register indexes past the list; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int NUM_CH      = NUM_CHANNELS_DEF;
  localparam int IDLE_PCT    = 12;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OPCODE_W-1:0]  in_opcode = OP_PWM_TICK;
  logic [CHANNEL_W-1:0] in_channel = '0;
  logic [DUTY_W-1:0]    in_width = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LEVELS_W-1:0]  out_led_levels;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PERIOD_MAX;
  logic [DUTY_W-1:0]    cfg_wdata = '0;

  // Shared idle rate for both sides; zero gives a stretch with no gaps.
  int idle_pct = IDLE_PCT;
  int mismatches = 0;
  int cycle_count = 0;

  // Expected LED levels, one per accepted word, oldest first.
  logic [LEVELS_W-1:0] levels_due[$];

  // Shadow of the driver: registers, period counter, duties and LED states.
  logic [DUTY_W-1:0]   period_max_r = PERIOD_MAX_RST;
  logic [DUTY_W-1:0]   duty_min_r = DUTY_MIN_RST;
  logic [DUTY_W-1:0]   pwm_count = '0;
  logic [DUTY_W-1:0]   duty_now[NUM_CH];
  logic [DUTY_W-1:0]   duty_goal[NUM_CH];
  logic [LEVELS_W-1:0] led_on = '0;

  four_channel_fading_pwm dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_channel     (in_channel),
    .in_width       (in_width),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_led_levels (out_led_levels),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Apply one word to the shadow state and return the LED levels after it.
  function automatic logic [LEVELS_W-1:0] apply_word(logic [OPCODE_W-1:0] op,
                                                     logic [CHANNEL_W-1:0] ch,
                                                     logic [DUTY_W-1:0] w);
    logic [DUTY_W-1:0] clamped;
    int i;
    if (op == OP_PWM_TICK) begin
      // wrap: every channel not parked at the minimum lights up
      if (pwm_count >= period_max_r) begin
        pwm_count = '0;
        for (i = 0; i < NUM_CH; i++)
          if (duty_now[i] != duty_min_r) led_on[i] = 1'b1;
      end
      // a duty equal to period_max never turns off
      for (i = 0; i < NUM_CH; i++)
        if (pwm_count >= duty_now[i] && duty_now[i] != period_max_r) led_on[i] = 1'b0;
      pwm_count = pwm_count + 1'b1;
    end else if (op == OP_RAMP_TICK) begin
      for (i = 0; i < NUM_CH; i++) begin
        if (duty_now[i] < duty_goal[i]) duty_now[i] = duty_now[i] + 1'b1;
        else if (duty_now[i] > duty_goal[i]) duty_now[i] = duty_now[i] - 1'b1;
      end
    end else if (op == OP_SET_DUTY) begin
      // limit to the max first, then raise to the min: min wins when crossed
      clamped = (w > period_max_r) ? period_max_r : w;
      if (clamped < duty_min_r) clamped = duty_min_r;
      if (ch == CH_ALL) begin
        for (i = 0; i < NUM_CH; i++) duty_goal[i] = clamped;
      end else if (ch >= 1 && ch <= NUM_CH) begin
        duty_goal[ch - 1] = clamped;
      end
    end
    return led_on;
  endfunction

  // Offer one word, holding it until accepted, then log its expectation.
  // Valid stays high afterwards until the next call or a drain changes it.
  task automatic send_word(logic [OPCODE_W-1:0] op, logic [CHANNEL_W-1:0] ch,
                           logic [DUTY_W-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_channel <= ch;
    in_width   <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    levels_due.push_back(apply_word(op, ch, w));
  endtask

  // Stop sending and let every expected word come back, plus pipeline slack.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write, only with the pipeline empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] val);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PERIOD_MAX: period_max_r = val;
      REG_DUTY_MIN:   duty_min_r = val;
      default: ;
    endcase
  endtask

  // Mostly fading traffic: pwm ticks, ramp ticks and legal set-duty words,
  // with a little noise (unused opcode, unknown channel, wild widths).
  task automatic send_random_word();
    int pick;
    int hi;
    logic [CHANNEL_W-1:0] ch;
    logic [DUTY_W-1:0] w;
    hi = int'(period_max_r) + 3;
    if (hi > 65535) hi = 65535;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_word(OP_PWM_TICK, CHANNEL_W'($urandom), DUTY_W'($urandom));
    end else if (pick < 77) begin
      send_word(OP_RAMP_TICK, CHANNEL_W'($urandom), DUTY_W'($urandom));
    end else if (pick < 92) begin
      ch = ($urandom_range(4) == 0) ? CH_ALL : CHANNEL_W'($urandom_range(1, NUM_CH));
      w = ($urandom_range(7) == 0) ? DUTY_W'($urandom) : DUTY_W'($urandom_range(hi));
      send_word(OP_SET_DUTY, ch, w);
    end else if (pick < 96) begin
      send_word(OP_UNUSED, CHANNEL_W'($urandom), DUTY_W'($urandom));
    end else begin
      ch = ($urandom_range(3) == 0) ? 8'd0 : CHANNEL_W'($urandom_range(NUM_CH + 1, 254));
      send_word(OP_SET_DUTY, ch, DUTY_W'($urandom));
    end
  endtask

  // Defaults right after reset, then every opcode and channel corner.
  task automatic test_opcodes_and_channels();
    send_word(OP_PWM_TICK, 8'd0, 16'd0);
    send_word(OP_UNUSED, 8'd1, 16'hffff);
    send_word(OP_SET_DUTY, 8'd1, 16'd0);
    send_word(OP_SET_DUTY, 8'd2, 16'hffff);   // clamps to period_max
    send_word(OP_SET_DUTY, 8'd3, 16'd50);
    send_word(OP_SET_DUTY, 8'd4, 16'd101);
    send_word(OP_SET_DUTY, 8'd0, 16'd30);     // unknown channels, ignored
    send_word(OP_SET_DUTY, 8'd5, 16'd30);
    send_word(OP_SET_DUTY, 8'd254, 16'd77);
    send_word(OP_SET_DUTY, 8'h80, 16'h5555);
    repeat (3) send_word(OP_RAMP_TICK, 8'hff, 16'haaaa);
    repeat (3) send_word(OP_PWM_TICK, 8'h00, 16'h0000);
    send_word(OP_SET_DUTY, CH_ALL, 16'hffff);
    send_word(OP_RAMP_TICK, 8'd0, 16'd0);
    send_word(OP_PWM_TICK, 8'd0, 16'd0);
  endtask

  // Register extremes: period_max of 1, min above max, spare indexes, longest period.
  task automatic test_register_extremes();
    write_reg(REG_PERIOD_MAX, 16'd1);
    send_word(OP_SET_DUTY, 8'd1, 16'd1);      // duty == period_max: always on
    send_word(OP_SET_DUTY, 8'd2, 16'd0);
    send_word(OP_RAMP_TICK, 8'd0, 16'd0);
    repeat (4) send_word(OP_PWM_TICK, 8'd0, 16'd0);
    write_reg(REG_DUTY_MIN, 16'hffff);
    send_word(OP_SET_DUTY, 8'd3, 16'd5);      // min wins over max
    send_word(OP_RAMP_TICK, 8'd0, 16'd0);
    repeat (2) send_word(OP_PWM_TICK, 8'd0, 16'd0);
    write_reg(REG_SPARE_A, 16'h1234);
    write_reg(REG_SPARE_B, 16'hffff);
    send_word(OP_PWM_TICK, 8'd0, 16'd0);
    write_reg(REG_PERIOD_MAX, 16'hffff);
    write_reg(REG_DUTY_MIN, 16'd0);
    send_word(OP_SET_DUTY, 8'd1, 16'hffff);
    send_word(OP_SET_DUTY, CH_ALL, 16'd0);
    send_word(OP_RAMP_TICK, 8'd0, 16'd0);
    repeat (3) send_word(OP_PWM_TICK, 8'd0, 16'd0);
  endtask

  // Random fading traffic over several register settings; halfway through the
  // first phase the sender holds off until the pipeline has drained.
  task automatic test_fade_phases();
    logic [DUTY_W-1:0] pmax_set[7];
    logic [DUTY_W-1:0] dmin_set[7];
    int p;
    int n;
    pmax_set = '{16'd16, 16'd1, 16'd7, 16'd24, 16'd100, 16'd5, 16'd2};
    dmin_set = '{16'd0, 16'd0, 16'd2, 16'd30, 16'd0, 16'd5, 16'd0};
    pmax_set[6] = DUTY_W'($urandom_range(2, 40));
    dmin_set[6] = DUTY_W'($urandom_range(0, pmax_set[6] / 2));
    for (p = 0; p < 7; p++) begin
      write_reg(REG_PERIOD_MAX, pmax_set[p]);
      write_reg(REG_DUTY_MIN, dmin_set[p]);
      for (n = 0; n < 90; n++) begin
        if (p == 0 && n == 45) wait_for_results();
        send_random_word();
      end
    end
  endtask

  // Back-to-back words with both sides always ready.
  task automatic test_no_idle_stretch();
    int n;
    write_reg(REG_PERIOD_MAX, 16'd10);
    write_reg(REG_DUTY_MIN, 16'd1);
    idle_pct = 0;
    for (n = 0; n < 150; n++) send_random_word();
    idle_pct = IDLE_PCT;
  endtask

  // Result side: random stalls and in-order compare against the oldest expectation.
  always @(posedge clk) begin : result_check
    logic [LEVELS_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: led_levels %h", out_led_levels);
      end else begin
        want = levels_due.pop_front();
        if (out_led_levels !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: led_levels expected %h, got %h", want, out_led_levels);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("four_channel_fading_pwm test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      duty_now[i] = DUTY_MIN_RST;
      duty_goal[i] = DUTY_MIN_RST;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_opcodes_and_channels();
    test_register_extremes();
    test_fade_phases();
    test_no_idle_stretch();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("four_channel_fading_pwm test passed");
    end else begin
      $display("four_channel_fading_pwm test failed");
    end
    $finish;
  end

endmodule
